// ===== hw/rtl/tracker_song_position_sequencer_macros.svh =====
// Assertion macros shared by the tracker song position sequencer RTL.
`ifndef TRACKER_SONG_POSITION_SEQUENCER_MACROS_SVH
`define TRACKER_SONG_POSITION_SEQUENCER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TSPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define TSPS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/tsps_pkg.sv =====
// Shared types, constants and helpers of the tracker song position sequencer.
package tsps_pkg;

   localparam int ORDER_DEPTH      = 256;
   localparam int PATTERN_COUNT    = 64;
   localparam int ROWS_PER_PATTERN = 64;
   localparam int TEMPO_DEPTH      = PATTERN_COUNT * ROWS_PER_PATTERN;

   localparam int ORDER_ADDR_W = $clog2(ORDER_DEPTH);
   localparam int TEMPO_ADDR_W = $clog2(TEMPO_DEPTH);
   localparam int POS_W        = 9;
   localparam int PAT_W        = 6;
   localparam int ROW_W        = 7;
   localparam int TICK_W       = 8;
   localparam int TEMPO_W      = 8;
   localparam int FRAME_W      = 32;
   localparam int MODE_W       = 3;
   localparam int INDEX_W      = 12;
   localparam int VALUE_W      = 8;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 32;

   localparam int REQ_FIELDS_W = 1 + INDEX_W + VALUE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + POS_W + PAT_W + ROW_W + TICK_W + TEMPO_W + FRAME_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [TEMPO_W-1:0] INITIAL_TEMPO_RESET = 8'd6;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK      = 3'd0,
      MODE_RESTART   = 3'd1,
      MODE_WR_ORDER  = 3'd2,
      MODE_WR_LENGTH = 3'd3,
      MODE_WR_TEMPO  = 3'd4
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INITIAL_TEMPO = 2'd0,
      CSR_ORDER_LENGTH  = 2'd1,
      CSR_LOOP_POSITION = 2'd2,
      CSR_LOOP_FRAME    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TEMPO_W-1:0]      initial_tempo;
      logic [POS_W-1:0]        order_length;
      logic [ORDER_ADDR_W-1:0] loop_position;
      logic [FRAME_W-1:0]      loop_frame;
   } cfg_type;

   typedef struct packed {
      mode_type             mode;
      logic                 looped;
      logic [INDEX_W-1:0]   table_index;
      logic [VALUE_W-1:0]   table_value;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [PAT_W-1:0]   pattern;
      logic [ROW_W-1:0]   row;
      logic [TICK_W-1:0]  tick;
      logic [TEMPO_W-1:0] tempo;
      logic [FRAME_W-1:0] frame;
   } cursor_type;

   typedef struct packed {
      logic take;
      logic busy;
   } eng_status_type;

   // The cursor plays while its position lies inside the order list,
   // whose length is capped at the order table depth.
   function automatic logic is_playing(input logic [POS_W-1:0] position,
                                       input logic [POS_W-1:0] order_length);
      logic [POS_W-1:0] len;
      len = (order_length > POS_W'(ORDER_DEPTH)) ? POS_W'(ORDER_DEPTH) : order_length;
      return position < len;
   endfunction

endpackage

// ===== hw/rtl/tsps_engine.sv =====
// Cursor engine: table memories, cursor state and the per-item sequencer.
module tsps_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  tsps_pkg::item_type       item,
   input  tsps_pkg::cfg_type        cfg,
   input  logic                     rsp_ready,
   output tsps_pkg::eng_status_type status,
   output logic                     rsp_valid,
   output tsps_pkg::cursor_type     cursor
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_POS,
      ST_ROW0
   } state_type;

   state_type                           state_ff, state_in;
   tsps_pkg::cursor_type                cur_ff, cur_in;
   logic                                may_loop_ff, may_loop_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic [tsps_pkg::PAT_W-1:0]          order_mem [tsps_pkg::ORDER_DEPTH];
   logic [tsps_pkg::ROW_W-1:0]          length_mem [tsps_pkg::PATTERN_COUNT];
   logic [tsps_pkg::TEMPO_W-1:0]        tempo_mem [tsps_pkg::TEMPO_DEPTH];

   logic                                order_we, length_we, tempo_we;
   logic [tsps_pkg::ORDER_ADDR_W-1:0]   order_waddr;
   logic [tsps_pkg::PAT_W-1:0]          order_wdata;
   logic [tsps_pkg::PAT_W-1:0]          length_waddr;
   logic [tsps_pkg::ROW_W-1:0]          length_wdata;
   logic [tsps_pkg::TEMPO_ADDR_W-1:0]   tempo_waddr;
   logic [tsps_pkg::TEMPO_W-1:0]        tempo_wdata;

   logic                                order_re, length_re, tempo_re;
   logic [tsps_pkg::ORDER_ADDR_W-1:0]   order_raddr;
   logic [tsps_pkg::PAT_W-1:0]          length_raddr;
   logic [tsps_pkg::TEMPO_ADDR_W-1:0]   tempo_raddr;
   logic [tsps_pkg::PAT_W-1:0]          order_q_ff;
   logic [tsps_pkg::ROW_W-1:0]          length_q_ff;
   logic [tsps_pkg::TEMPO_W-1:0]        tempo_q_ff;

   logic                                take, done, out_free, playing_now;
   logic [tsps_pkg::TICK_W:0]           tick_inc;
   logic [tsps_pkg::ROW_W-1:0]          next_row;

   function automatic logic [tsps_pkg::TEMPO_ADDR_W-1:0] tempo_addr(
      input logic [tsps_pkg::PAT_W-1:0] pattern,
      input logic [tsps_pkg::ROW_W-1:0] row);
      return tsps_pkg::TEMPO_ADDR_W'(pattern) *
             tsps_pkg::TEMPO_ADDR_W'(tsps_pkg::ROWS_PER_PATTERN) +
             tsps_pkg::TEMPO_ADDR_W'(row);
   endfunction

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign playing_now = tsps_pkg::is_playing(cur_ff.position, cfg.order_length);
   assign tick_inc    = {1'b0, cur_ff.tick} + (tsps_pkg::TICK_W + 1)'(1);
   assign next_row    = cur_ff.row + tsps_pkg::ROW_W'(1);

   assign order_waddr  = item.table_index[tsps_pkg::ORDER_ADDR_W-1:0];
   assign order_wdata  = tsps_pkg::PAT_W'(item.table_value);
   assign length_waddr = item.table_index[tsps_pkg::PAT_W-1:0];
   assign length_wdata = (32'(item.table_value) > 32'(tsps_pkg::ROWS_PER_PATTERN)) ?
                         tsps_pkg::ROW_W'(tsps_pkg::ROWS_PER_PATTERN) :
                         tsps_pkg::ROW_W'(item.table_value);
   assign tempo_waddr  = item.table_index[tsps_pkg::TEMPO_ADDR_W-1:0];
   assign tempo_wdata  = item.table_value;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      may_loop_in  = may_loop_ff;
      take         = 1'b0;
      done         = 1'b0;
      order_we     = 1'b0;
      length_we    = 1'b0;
      tempo_we     = 1'b0;
      order_re     = 1'b0;
      length_re    = 1'b0;
      tempo_re     = 1'b0;
      order_raddr  = '0;
      length_raddr = cur_ff.pattern;
      tempo_raddr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && out_free) begin
               take = 1'b1;
               case (item.mode)
                  tsps_pkg::MODE_TICK: begin
                     may_loop_in = item.looped;
                     if (playing_now) begin
                        cur_in.frame = cur_ff.frame + tsps_pkg::FRAME_W'(1);
                        if (tick_inc < {1'b0, cur_ff.tempo}) begin
                           cur_in.tick = tick_inc[tsps_pkg::TICK_W-1:0];
                           done        = 1'b1;
                        end else begin
                           length_re    = 1'b1;
                           length_raddr = cur_ff.pattern;
                           tempo_re     = 1'b1;
                           tempo_raddr  = tempo_addr(cur_ff.pattern, next_row);
                           state_in     = ST_ROW;
                        end
                     end else begin
                        done = 1'b1;
                     end
                  end
                  tsps_pkg::MODE_RESTART: begin
                     cur_in.frame    = '0;
                     cur_in.tempo    = cfg.initial_tempo;
                     cur_in.position = '0;
                     may_loop_in     = 1'b0;
                     order_re        = 1'b1;
                     order_raddr     = '0;
                     state_in        = ST_POS;
                  end
                  tsps_pkg::MODE_WR_ORDER: begin
                     order_we = (32'(item.table_index) < 32'(tsps_pkg::ORDER_DEPTH)) &&
                                (32'(item.table_value) < 32'(tsps_pkg::PATTERN_COUNT));
                     done     = 1'b1;
                  end
                  tsps_pkg::MODE_WR_LENGTH: begin
                     length_we = 32'(item.table_index) < 32'(tsps_pkg::PATTERN_COUNT);
                     done      = 1'b1;
                  end
                  tsps_pkg::MODE_WR_TEMPO: begin
                     tempo_we = 32'(item.table_index) < 32'(tsps_pkg::TEMPO_DEPTH);
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_ROW: begin
            cur_in.tick = '0;
            if (next_row < length_q_ff) begin
               cur_in.row = next_row;
               if (tempo_q_ff != '0) begin
                  cur_in.tempo = tempo_q_ff;
               end
               done = 1'b1;
            end else begin
               cur_in.row      = '0;
               cur_in.position = cur_ff.position + tsps_pkg::POS_W'(1);
               order_re        = 1'b1;
               order_raddr     = cur_in.position[tsps_pkg::ORDER_ADDR_W-1:0];
               state_in        = ST_POS;
            end
         end
         ST_POS: begin
            cur_in.row  = '0;
            cur_in.tick = '0;
            if (playing_now) begin
               cur_in.pattern = order_q_ff;
               length_re      = 1'b1;
               length_raddr   = order_q_ff;
               tempo_re       = 1'b1;
               tempo_raddr    = tempo_addr(order_q_ff, '0);
               state_in       = ST_ROW0;
            end else begin
               cur_in.pattern = '0;
               if (may_loop_ff) begin
                  cur_in.frame    = cfg.loop_frame;
                  cur_in.tempo    = cfg.initial_tempo;
                  cur_in.position = (cfg.loop_frame != '0) ?
                                    tsps_pkg::POS_W'(cfg.loop_position) : '0;
                  may_loop_in     = 1'b0;
                  order_re        = 1'b1;
                  order_raddr     = cur_in.position[tsps_pkg::ORDER_ADDR_W-1:0];
               end else begin
                  done = 1'b1;
               end
            end
         end
         ST_ROW0: begin
            if (length_q_ff != '0 && tempo_q_ff != '0) begin
               cur_in.tempo = tempo_q_ff;
            end
            done = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         may_loop_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '{position: '0, pattern: '0, row: '0, tick: '0,
                           tempo: tsps_pkg::INITIAL_TEMPO_RESET, frame: '0};
      end else begin
         state_ff     <= state_in;
         may_loop_ff  <= may_loop_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      if (order_re) begin
         order_q_ff <= order_mem[order_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (length_we) begin
         length_mem[length_waddr] <= length_wdata;
      end
      if (length_re) begin
         length_q_ff <= length_mem[length_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tempo_we) begin
         tempo_mem[tempo_waddr] <= tempo_wdata;
      end
      if (tempo_re) begin
         tempo_q_ff <= tempo_mem[tempo_raddr];
      end
   end

   assign status.take = take;
   assign status.busy = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cursor      = cur_ff;

endmodule

// ===== hw/rtl/tracker_song_position_sequencer.sv =====
// Top level of the tracker song position sequencer: ports, registers, buffering.
//
// Each request transfer carries one item: a tick, a restart, or a write into the
// order, pattern length or row tempo table (selected by req_tuser). Each item
// yields exactly one response transfer showing the cursor after the item.
// An item is held in a one-entry input buffer and handed to the engine when no
// result is waiting, so a new request is taken in every cycle in which the
// previous one moves on. Table writes, unknown items and ticks that stay in a row
// or find the song stopped finish in the idle state; a restart passes the position
// step and, if the song plays, the first row step; a row change the row step; a
// position change the row and position steps and, if the song plays, the first
// row step; a loop back one more position step. Each step waits on a synchronous
// memory read. The result sits in a register until the receiver takes it; while
// the receiver stalls, the engine holds and the input buffer fills and then
// deasserts req_tready. Reset clears the cursor, sets the tempo to six and the
// registers to their defaults; the table memories are not cleared and must be
// loaded before use. Registers are written through csr_we; the user must do so
// only while the block idles, and the block itself does not enforce it.
`include "tracker_song_position_sequencer_macros.svh"

module tracker_song_position_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // looped, table_index, table_value, zero fill
   input  logic [tsps_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode
   input  logic [tsps_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // playing, order_position, pattern_number, row, tick, tempo, frame_count, zero fill
   output logic [tsps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [tsps_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tsps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tsps_pkg::cfg_type          cfg_ff;
   tsps_pkg::item_type         buf_item_ff;
   logic                       buf_valid_ff, buf_valid_in;
   logic                       req_accept;
   tsps_pkg::eng_status_type   status;
   tsps_pkg::cursor_type       cursor;
   logic                       playing;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{initial_tempo: tsps_pkg::INITIAL_TEMPO_RESET, order_length: '0,
                     loop_position: '0, loop_frame: '0};
      end else if (csr_we) begin
         unique case (tsps_pkg::csr_index_type'(csr_addr))
            tsps_pkg::CSR_INITIAL_TEMPO: begin
               cfg_ff.initial_tempo <= csr_wdata[tsps_pkg::TEMPO_W-1:0];
            end
            tsps_pkg::CSR_ORDER_LENGTH: begin
               cfg_ff.order_length <= csr_wdata[tsps_pkg::POS_W-1:0];
            end
            tsps_pkg::CSR_LOOP_POSITION: begin
               cfg_ff.loop_position <= csr_wdata[tsps_pkg::ORDER_ADDR_W-1:0];
            end
            tsps_pkg::CSR_LOOP_FRAME: begin
               cfg_ff.loop_frame <= csr_wdata[tsps_pkg::FRAME_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_tready   = !buf_valid_ff || status.take;
   assign req_accept   = req_tvalid && req_tready;
   assign buf_valid_in = req_accept || (buf_valid_ff && !status.take);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         buf_item_ff.mode        <= tsps_pkg::mode_type'(req_tuser);
         buf_item_ff.looped      <= req_tdata[0];
         buf_item_ff.table_index <= req_tdata[tsps_pkg::INDEX_W:1];
         buf_item_ff.table_value <= req_tdata[tsps_pkg::INDEX_W+tsps_pkg::VALUE_W:
                                              tsps_pkg::INDEX_W+1];
      end
   end

   tsps_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (buf_valid_ff),
      .item       (buf_item_ff),
      .cfg        (cfg_ff),
      .rsp_ready  (rsp_tready),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .cursor     (cursor)
   );

   assign playing   = tsps_pkg::is_playing(cursor.position, cfg_ff.order_length);
   assign rsp_tdata = {(tsps_pkg::RSP_TDATA_W - tsps_pkg::RSP_FIELDS_W)'(0),
                       cursor.frame, cursor.tempo, cursor.tick, cursor.row,
                       cursor.pattern, cursor.position, playing};

   `TSPS_ASSERT(a_idle_while_result_waits, !(status.busy && rsp_tvalid), "engine busy while a result waits")
   `TSPS_ASSERT(a_result_from_work, $rose(rsp_tvalid) |-> $past(status.busy || status.take), "result without work")
   `TSPS_ASSERT(a_position_in_range, 32'(cursor.position) <= 32'(tsps_pkg::ORDER_DEPTH), "position past order depth")
   `TSPS_ASSERT_NEXT(a_no_repeat, rsp_tvalid && rsp_tready && !status.take, !rsp_tvalid, "result repeated")

endmodule
